// ----- hw/rtl/wrp_pkg.sv -----
// Package for the weighted rendezvous placer: opcodes, status codes,
// hash constants and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package wrp_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_ID   = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_BAD_WT    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_NO_ACTIVE = 3'd6;
  localparam logic [2:0] ST_RANGE     = 3'd7;

  localparam logic [63:0] SEED_RESET = 64'h4c53504c41434531;
  localparam logic [63:0] MUL_A      = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_B      = 64'h94d049bb133111eb;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CHK,
    S_SALT,
    S_SALT_WAIT,
    S_ENT_RD,
    S_ENT_CHK,
    S_TICK,
    S_TICK_WAIT,
    S_DONE,
    S_OUT
  } state_t;

  // finalizer op: which input the hash unit mixes
  typedef enum logic [1:0] {
    HSEL_SALT,
    HSEL_TICKET
  } hsel_t;

  typedef struct packed {
    logic  load_item;   // latch input item
    logic  clr_table;   // entry_count and ticket_total to zero
    logic  commit;      // append loaded worker
    logic  idx_clr;     // entry index to zero
    logic  idx_inc;     // next entry
    logic  tick_clr;    // ticket counter to zero
    logic  tick_inc;    // next ticket
    logic  hash_go;     // start finalizer
    hsel_t hash_sel;
    logic  salt_ld;     // capture finalizer result as salt
    logic  score_upd;   // compare finalizer result with best
    logic  best_clr;
    logic  res_ld;      // load result register
    logic [2:0] res_st;
    logic  res_place;   // result carries owner and score
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       zero_id;
    logic       bad_wt;
    logic       overflow;
    logic       full;
    logic       range_err;
    logic       idx_end;    // index reached entry_count
    logic       id_match;   // read entry id equals item id
    logic       ent_live;   // read entry active with weight
    logic       tick_last;  // ticket is the last of entry
    logic       hash_done;
    logic       found;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wrp_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module wrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/wrp_hash.sv -----
// Iterative splitmix64 finalizer: xorshift, multiply, xorshift, multiply,
// xorshift, with each 64x64 multiply done as 16 partial products.
// Depends on wrp_pkg.
`default_nettype none
module wrp_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] din,
  output logic             done,
  output logic [63:0]      dout
);
  // phase: 0 mul A, 1 mul B, 2 final shift
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] op_r, op_nxt;
  logic [63:0] v_r, v_nxt;
  logic [3:0]  pp_r, pp_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  logic [1:0]  ai, bi;
  logic [15:0] a_part, b_part;
  logic [31:0] prod;
  logic [63:0] term;
  logic [63:0] mulc;
  logic [63:0] sum;

  always_comb begin
    mulc   = (ph_r == 2'd0) ? wrp_pkg::MUL_A : wrp_pkg::MUL_B;
    ai     = pp_r[1:0];
    bi     = pp_r[3:2];
    a_part = op_r[16*ai +: 16];
    b_part = mulc[16*bi +: 16];
    prod   = a_part * b_part;
    term   = 64'({32'd0, prod} << (16 * (ai + bi)));
    sum    = acc_r + term;
  end

  always_comb begin
    acc_nxt  = acc_r;
    op_nxt   = op_r;
    v_nxt    = v_r;
    pp_nxt   = pp_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      op_nxt   = din ^ (din >> 30);
      acc_nxt  = '0;
      pp_nxt   = '0;
      ph_nxt   = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ph_r == 2'd2) begin
        v_nxt    = v_r ^ (v_r >> 31);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // skip partial products that land above bit 63
        acc_nxt = (32'(ai) + 32'(bi) <= 32'd3) ? sum : acc_r;
        pp_nxt  = pp_r + 4'd1;
        if (pp_r == 4'hf) begin
          if (ph_r == 2'd0) begin
            op_nxt  = acc_nxt ^ (acc_nxt >> 27);
            acc_nxt = '0;
            ph_nxt  = 2'd1;
          end else begin
            v_nxt  = acc_nxt;
            ph_nxt = 2'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    op_r  <= op_nxt;
    v_r   <= v_nxt;
    pp_r  <= pp_nxt;
    ph_r  <= ph_nxt;
  end

  assign done = done_r;
  assign dout = v_r;
endmodule
`default_nettype wire

// ----- hw/rtl/wrp_datapath.sv -----
// Placer datapath: worker table RAM, counters, hash unit, best tracker and
// result register.  Depends on wrp_pkg, wrp_ram and wrp_hash.
`default_nettype none
module wrp_datapath #(
  parameter int MAX_WORKERS = 16,
  parameter int MAX_WEIGHT  = 256,
  parameter int MAX_TICKETS = 4096,
  parameter int SHARD_COUNT = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wrp_pkg::cmd_t   cmd,
  output wrp_pkg::sts_t        sts,
  input  wire logic [63:0]     seed,
  input  wire logic [1:0]      in_opcode,
  input  wire logic [31:0]     in_node_id,
  input  wire logic [15:0]     in_worker_weight,
  input  wire logic            in_worker_active,
  input  wire logic [15:0]     in_shard_index,
  output logic [2:0]           res_status,
  output logic [31:0]          res_owner_id,
  output logic [63:0]          res_best_score
);
  localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam int TW = $clog2(MAX_TICKETS + 1);
  localparam int ENT_W = 32 + 16 + 1;

  logic [1:0]  op_r;
  logic [31:0] id_r;
  logic [15:0] wt_r, shard_r;
  logic        act_r;
  logic [CW-1:0] cnt_r;
  logic [TW-1:0] tot_r;
  logic [CW-1:0] idx_r;
  logic [15:0]   tick_r;
  logic [63:0]   salt_r, best_r;
  logic [31:0]   best_id_r;
  logic          found_r;

  logic [ENT_W-1:0] rd_data;
  logic [31:0] e_id;
  logic [15:0] e_wt;
  logic        e_act;
  logic        h_done;
  logic [63:0] h_out, h_in;
  logic [16:0] tot_sum;

  assign e_id  = rd_data[ENT_W-1 -: 32];
  assign e_wt  = rd_data[16:1];
  assign e_act = rd_data[0];

  wrp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WORKERS)) u_tab (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (cnt_r[IW-1:0]),
    .wdata ({id_r, wt_r, act_r}),
    .raddr (idx_r[IW-1:0]),
    .rdata (rd_data)
  );

  assign h_in = (cmd.hash_sel == wrp_pkg::HSEL_SALT)
              ? (seed ^ {48'd0, shard_r})
              : ({e_id, 16'd0, tick_r} ^ salt_r);

  wrp_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_go),
    .din   (h_in),
    .done  (h_done),
    .dout  (h_out)
  );

  assign tot_sum = 17'(tot_r) + 17'(wt_r);

  always_comb begin
    sts.opcode    = op_r;
    sts.zero_id   = (id_r == 32'd0);
    sts.bad_wt    = (wt_r == 16'd0) || (32'(wt_r) > MAX_WEIGHT);
    sts.overflow  = (32'(tot_sum) > MAX_TICKETS);
    sts.full      = (32'(cnt_r) >= MAX_WORKERS);
    sts.range_err = (32'(shard_r) >= SHARD_COUNT);
    sts.idx_end   = (idx_r >= cnt_r);
    sts.id_match  = (e_id == id_r);
    sts.ent_live  = e_act && (e_wt != 16'd0);
    sts.tick_last = (tick_r + 16'd1 == e_wt);
    sts.hash_done = h_done;
    sts.found     = found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tot_r <= '0;
    end else if (cmd.clr_table) begin
      cnt_r <= '0;
      tot_r <= '0;
    end else if (cmd.commit) begin
      cnt_r <= cnt_r + CW'(1);
      tot_r <= TW'(tot_sum);
    end
    if (cmd.load_item) begin
      op_r    <= in_opcode;
      id_r    <= in_node_id;
      wt_r    <= in_worker_weight;
      act_r   <= in_worker_active;
      shard_r <= in_shard_index;
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
    if (cmd.tick_clr) tick_r <= '0;
    else if (cmd.tick_inc) tick_r <= tick_r + 16'd1;
    if (cmd.salt_ld) salt_r <= h_out;
    // keep the higher score, the lower id on a tie
    if (cmd.best_clr) begin
      found_r   <= 1'b0;
      best_r    <= '0;
      best_id_r <= '0;
    end else if (cmd.score_upd) begin
      if (!found_r || h_out > best_r || (h_out == best_r && e_id < best_id_r)) begin
        found_r   <= 1'b1;
        best_r    <= h_out;
        best_id_r <= e_id;
      end
    end
    if (cmd.res_ld) begin
      res_status     <= cmd.res_st;
      res_owner_id   <= cmd.res_place ? best_id_r : 32'd0;
      res_best_score <= cmd.res_place ? best_r : 64'd0;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/wrp_ctrl.sv -----
// Placer controller: sequences load checks, salt hashing and the ticket
// scan, and runs the input and output handshakes.  Depends on wrp_pkg.
`default_nettype none
module wrp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_fire,
  output wrp_pkg::cmd_t       cmd,
  input  wire wrp_pkg::sts_t  sts
);
  wrp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= wrp_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.hash_sel = wrp_pkg::HSEL_SALT;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      wrp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_item = 1'b1;
          cmd.idx_clr   = 1'b1;
          cmd.best_clr  = 1'b1;
          state_nxt     = wrp_pkg::S_DUP_RD;
        end
      end
      wrp_pkg::S_DUP_RD: begin
        // dispatch on the latched opcode; RAM read of the current entry under way
        cmd.res_ld = 1'b1;
        cmd.res_st = wrp_pkg::ST_OK;
        unique case (sts.opcode)
          wrp_pkg::OP_CLEAR: begin
            cmd.clr_table = 1'b1;
            state_nxt     = wrp_pkg::S_OUT;
          end
          wrp_pkg::OP_LOAD: begin
            if (sts.zero_id) begin
              cmd.res_st = wrp_pkg::ST_ZERO_ID;
              state_nxt  = wrp_pkg::S_OUT;
            end else begin
              cmd.res_ld = 1'b0;
              state_nxt  = wrp_pkg::S_DUP_CHK;
            end
          end
          wrp_pkg::OP_PLACE: begin
            if (sts.range_err) begin
              cmd.res_st = wrp_pkg::ST_RANGE;
              state_nxt  = wrp_pkg::S_OUT;
            end else begin
              cmd.res_ld = 1'b0;
              state_nxt  = wrp_pkg::S_SALT;
            end
          end
          default: state_nxt = wrp_pkg::S_OUT;
        endcase
      end
      wrp_pkg::S_DUP_CHK: begin
        // RAM data valid for current index
        if (!sts.idx_end && sts.id_match) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = wrp_pkg::ST_DUP;
          state_nxt  = wrp_pkg::S_OUT;
        end else if (!sts.idx_end) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = wrp_pkg::S_DUP_RD;
        end else begin
          cmd.res_ld = 1'b1;
          state_nxt  = wrp_pkg::S_OUT;
          if (sts.bad_wt)        cmd.res_st = wrp_pkg::ST_BAD_WT;
          else if (sts.overflow) cmd.res_st = wrp_pkg::ST_OVERFLOW;
          else if (sts.full)     cmd.res_st = wrp_pkg::ST_FULL;
          else begin
            cmd.res_st = wrp_pkg::ST_OK;
            cmd.commit = 1'b1;
          end
        end
      end
      wrp_pkg::S_SALT: begin
        cmd.hash_go  = 1'b1;
        cmd.hash_sel = wrp_pkg::HSEL_SALT;
        state_nxt    = wrp_pkg::S_SALT_WAIT;
      end
      wrp_pkg::S_SALT_WAIT: begin
        if (sts.hash_done) begin
          cmd.salt_ld = 1'b1;
          state_nxt   = wrp_pkg::S_ENT_RD;
        end
      end
      wrp_pkg::S_ENT_RD: begin
        cmd.tick_clr = 1'b1;
        state_nxt    = wrp_pkg::S_ENT_CHK;
      end
      wrp_pkg::S_ENT_CHK: begin
        if (sts.idx_end) begin
          state_nxt = wrp_pkg::S_DONE;
        end else if (sts.ent_live) begin
          state_nxt = wrp_pkg::S_TICK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = wrp_pkg::S_ENT_RD;
        end
      end
      wrp_pkg::S_TICK: begin
        cmd.hash_go  = 1'b1;
        cmd.hash_sel = wrp_pkg::HSEL_TICKET;
        state_nxt    = wrp_pkg::S_TICK_WAIT;
      end
      wrp_pkg::S_TICK_WAIT: begin
        if (sts.hash_done) begin
          cmd.score_upd = 1'b1;
          if (sts.tick_last) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = wrp_pkg::S_ENT_RD;
          end else begin
            cmd.tick_inc = 1'b1;
            state_nxt    = wrp_pkg::S_TICK;
          end
        end
      end
      wrp_pkg::S_DONE: begin
        cmd.res_ld    = 1'b1;
        cmd.res_place = sts.found;
        cmd.res_st    = sts.found ? wrp_pkg::ST_OK : wrp_pkg::ST_NO_ACTIVE;
        state_nxt     = wrp_pkg::S_OUT;
      end
      wrp_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = wrp_pkg::S_IDLE;
      end
      default: state_nxt = wrp_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/weighted_rendezvous_placer.sv -----
// Weighted rendezvous placer top level: seed register, controller and
// datapath.  Depends on wrp_pkg, wrp_ctrl and wrp_datapath.
//
//   channel | direction | contents
//   in_     | slave     | tdata: opcode, node_id, worker_weight, worker_active, shard_index
//   out_    | master    | tdata: status, owner_id, best_score
//   cfg_    | write     | hash_seed
//
// One item at a time. A clear or a zero-id load registers its result in
// the dispatch state; a load first scans every stored entry for a
// duplicate id (read, then check). A placement hashes the salt, then reads
// and checks each stored entry and hashes every ticket of every active
// worker on the shared finalizer (two 16-step multiplies).
// Synchronous active-low reset empties the table; the seed returns to its
// default. A result stalled on out_tready holds the block until taken.
`default_nettype none
module weighted_rendezvous_placer #(
  parameter int MAX_WORKERS = 16,
  parameter int MAX_WEIGHT  = 256,
  parameter int MAX_TICKETS = 4096,
  parameter int SHARD_COUNT = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[1:0], node_id[33:2], worker_weight[49:34],
  // worker_active[50], shard_index[66:51], zero fill [71:67]
  input  wire logic [71:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[2:0], owner_id[34:3], best_score[98:35], zero fill [103:99]
  output logic [103:0]      out_tdata
);
  logic [63:0] seed_r;
  wrp_pkg::cmd_t cmd;
  wrp_pkg::sts_t sts;
  logic [2:0]  res_status;
  logic [31:0] res_owner_id;
  logic [63:0] res_best_score;

  // hold the seed register
  always_ff @(posedge clk) begin
    if (!rst_n)      seed_r <= wrp_pkg::SEED_RESET;
    else if (cfg_we) seed_r <= cfg_wdata;
  end

  wrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_fire  (out_tvalid && out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  wrp_datapath #(
    .MAX_WORKERS (MAX_WORKERS),
    .MAX_WEIGHT  (MAX_WEIGHT),
    .MAX_TICKETS (MAX_TICKETS),
    .SHARD_COUNT (SHARD_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .seed             (seed_r),
    .in_opcode        (in_tdata[1:0]),
    .in_node_id       (in_tdata[33:2]),
    .in_worker_weight (in_tdata[49:34]),
    .in_worker_active (in_tdata[50]),
    .in_shard_index   (in_tdata[66:51]),
    .res_status       (res_status),
    .res_owner_id     (res_owner_id),
    .res_best_score   (res_best_score)
  );

  assign out_tdata = {5'd0, res_best_score, res_owner_id, res_status};
endmodule
`default_nettype wire
